@@ rtl/slxfp_pkg.sv @@
// Shared types and constants for the sync/length/XOR frame parser.
// Used by sync_length_xor_frame_parser; depends on nothing else.
package slxfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned EVENT_W = 2;
  localparam int unsigned CFG_A_W = 1;
  // data, index, frame_length, command, computed_sum
  localparam int unsigned OUT_DATA_W = 5 * BYTE_W;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_SYNC_SECOND = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_PAYLOAD   = 2'd0,
    EV_FRAME_OK  = 2'd1,
    EV_CHECK_ERR = 2'd2
  } event_t;

  typedef struct packed {
    event_t            ev;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] idx;
    logic              last;
    logic [BYTE_W-1:0] flen;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] csum;
  } result_t;

endpackage

@@ rtl/sync_length_xor_frame_parser.sv @@
// Frame parser: two sync bytes, a length byte, payload, XOR checksum byte.
// Uses slxfp_pkg for the phase and event types and the result word layout.
//
// One received byte per word on the input stream, one byte per clock while
// in_tready is high. Each byte is decoded in the cycle it is accepted and
// its result, if any, is registered in the output or skid register.
// A skid register behind the output register lets one more byte be taken
// while a result waits; in_tready drops only when both hold a result.
// Sync, length and ignored hunt bytes give no output word. Payload bytes
// come out with their index (tlast on the final one); the checksum byte
// gives a frame-ok or checksum-error word. Write the sync registers only
// while the block is idle.
module sync_length_xor_frame_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [slxfp_pkg::CFG_A_W-1:0]      cfg_addr,
  input  logic [slxfp_pkg::BYTE_W-1:0]       cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [slxfp_pkg::BYTE_W-1:0]       in_tdata,   // [7:0] rx_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] data, [15:8] index, [23:16] frame_length, [31:24] command,
  // [39:32] computed_sum
  output logic [slxfp_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [slxfp_pkg::EVENT_W-1:0]      out_tuser,  // [1:0] event_res
  output logic                               out_tlast   // is_last
);

  logic [slxfp_pkg::BYTE_W-1:0] sync_first_r, sync_second_r;

  slxfp_pkg::phase_t            phase_r, phase_nxt;
  logic [slxfp_pkg::BYTE_W-1:0] payload_len_r, payload_len_nxt;
  logic [slxfp_pkg::BYTE_W-1:0] byte_count_r, byte_count_nxt;
  logic [slxfp_pkg::BYTE_W-1:0] running_sum_r, running_sum_nxt;
  logic [slxfp_pkg::BYTE_W-1:0] first_payload_r, first_payload_nxt;

  slxfp_pkg::result_t res;
  logic               res_valid;

  slxfp_pkg::result_t out_r, skid_r;
  logic               out_valid_r, skid_valid_r;

  logic                         in_acc;
  logic                         out_load;
  logic [slxfp_pkg::BYTE_W-1:0] b;
  logic                         is_last_byte;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = !out_valid_r || out_tready;
  assign b         = in_tdata;
  assign is_last_byte = ((byte_count_r + slxfp_pkg::BYTE_W'(1)) == payload_len_r);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= slxfp_pkg::SYNC_FIRST_RST;
      sync_second_r <= slxfp_pkg::SYNC_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        slxfp_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        slxfp_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= slxfp_pkg::PH_HUNT1;
      payload_len_r   <= '0;
      byte_count_r    <= '0;
      running_sum_r   <= '0;
      first_payload_r <= '0;
    end else if (in_acc) begin
      phase_r         <= phase_nxt;
      payload_len_r   <= payload_len_nxt;
      byte_count_r    <= byte_count_nxt;
      running_sum_r   <= running_sum_nxt;
      first_payload_r <= first_payload_nxt;
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    payload_len_nxt   = payload_len_r;
    byte_count_nxt    = byte_count_r;
    running_sum_nxt   = running_sum_r;
    first_payload_nxt = first_payload_r;
    res_valid         = 1'b0;
    res.ev            = slxfp_pkg::EV_PAYLOAD;
    res.data          = b;
    res.idx           = '0;
    res.last          = 1'b0;
    case (phase_r)
      slxfp_pkg::PH_HUNT2: begin
        // a rejected byte is not retried as a first sync byte
        phase_nxt = (b == sync_second_r) ? slxfp_pkg::PH_LEN : slxfp_pkg::PH_HUNT1;
      end
      slxfp_pkg::PH_LEN: begin
        payload_len_nxt   = b;
        byte_count_nxt    = '0;
        running_sum_nxt   = b;
        first_payload_nxt = '0;
        // empty frame: go straight to the checksum byte
        phase_nxt = (b == '0) ? slxfp_pkg::PH_CHECK : slxfp_pkg::PH_PAYLOAD;
      end
      slxfp_pkg::PH_PAYLOAD: begin
        if (byte_count_r == '0) first_payload_nxt = b;
        running_sum_nxt = running_sum_r ^ b;
        byte_count_nxt  = byte_count_r + slxfp_pkg::BYTE_W'(1);
        if (is_last_byte) phase_nxt = slxfp_pkg::PH_CHECK;
        res_valid = 1'b1;
        res.idx   = byte_count_r;
        res.last  = is_last_byte;
      end
      slxfp_pkg::PH_CHECK: begin
        phase_nxt = slxfp_pkg::PH_HUNT1;
        res_valid = 1'b1;
        res.ev    = (b == running_sum_r) ? slxfp_pkg::EV_FRAME_OK
                                         : slxfp_pkg::EV_CHECK_ERR;
      end
      default: begin
        phase_nxt = (b == sync_first_r) ? slxfp_pkg::PH_HUNT2 : slxfp_pkg::PH_HUNT1;
      end
    endcase
    res.flen = payload_len_nxt;
    res.cmd  = first_payload_nxt;
    res.csum = running_sum_nxt;
  end

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc && res_valid;
      end
    end else if (in_acc && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_acc && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.ev;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {out_r.csum, out_r.cmd, out_r.flen, out_r.idx, out_r.data};

  // skid only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while output register is empty");

  a_last_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == slxfp_pkg::PH_PAYLOAD && is_last_byte)
      |=> phase_r == slxfp_pkg::PH_CHECK)
    else $error("final payload byte did not move to checksum phase");

  a_check_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == slxfp_pkg::PH_CHECK) |=> phase_r == slxfp_pkg::PH_HUNT1)
    else $error("checksum byte did not return to hunting");

  a_end_word_no_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != slxfp_pkg::EV_PAYLOAD) |-> !out_tlast)
    else $error("frame end word carries tlast");

  a_no_result_in_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !skid_valid_r && out_valid_r && !out_tready
      && phase_r == slxfp_pkg::PH_HUNT1) |=> !skid_valid_r)
    else $error("hunt byte produced an output word");

endmodule
